/* hdl/s2c_pkg.sv */
package s2c_pkg;

    // default number of cordic iterations and the size of the arctangent table
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ANG_TABLE_LEN     = 24;

    // fixed-point constants: angles in 2^-28 rad, sine and cosine in q2.30
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [31:0] PI_Q28          = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q28     = 32'sd421657428;
    localparam logic signed [63:0] HALF_Q30        = 64'sd536870912;

    typedef struct packed {
        logic signed [15:0] azimuth_angle;
        logic signed [15:0] polar_angle;
        logic signed [15:0] radius;
    } point_t;

    typedef struct packed {
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic signed [15:0] z_coord;
    } coord_t;

    // round(atan(2^-i) * 2^28)
    function automatic logic signed [31:0] atan_q28(input int unsigned idx);
        logic signed [31:0] a;
        case (idx)
            0:       a = 32'sd210828714;
            1:       a = 32'sd124459457;
            2:       a = 32'sd65760959;
            3:       a = 32'sd33381290;
            4:       a = 32'sd16755422;
            5:       a = 32'sd8385879;
            6:       a = 32'sd4193963;
            7:       a = 32'sd2097109;
            8:       a = 32'sd1048571;
            9:       a = 32'sd524287;
            10:      a = 32'sd262144;
            11:      a = 32'sd131072;
            12:      a = 32'sd65536;
            13:      a = 32'sd32768;
            14:      a = 32'sd16384;
            15:      a = 32'sd8192;
            16:      a = 32'sd4096;
            17:      a = 32'sd2048;
            18:      a = 32'sd1024;
            19:      a = 32'sd512;
            20:      a = 32'sd256;
            21:      a = 32'sd128;
            22:      a = 32'sd64;
            23:      a = 32'sd32;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

endpackage

/* hdl/spherical_to_cartesian.sv */
// spherical to cartesian conversion, one mesh point per transfer
// throughput: one point per cycle while the output is not stalled, set by the fully unrolled cordic pipeline
// stall: one global advance enable, no point is lost or repeated while coord_ready is low
// reset: rst_n async active low clears all stage valid bits, data registers are not reset
module spherical_to_cartesian #(
    parameter int CORDIC_STAGES = s2c_pkg::CORDIC_STAGES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             point_valid,
    output logic             point_ready,
    input  s2c_pkg::point_t  point,
    output logic             coord_valid,
    input  logic             coord_ready,
    output s2c_pkg::coord_t  coord
);

    // iterations beyond the table length are not run
    localparam int NSTG  = (CORDIC_STAGES > s2c_pkg::ANG_TABLE_LEN) ?
                           s2c_pkg::ANG_TABLE_LEN : CORDIC_STAGES;
    // fold stage, NSTG cordic stages, two multiply stages, two rounding stages
    localparam int DEPTH = NSTG + 5;

    typedef struct packed {
        logic signed [31:0] z;
        logic               flip;
    } fold_t;

    // bring an angle into [-pi/2, pi/2]; flip marks sine and cosine to be negated
    function automatic fold_t fold_angle(input logic signed [15:0] ang);
        fold_t              f;
        logic signed [31:0] z;
        z = {ang[15], ang, 15'b0};
        f.flip = 1'b0;
        f.z    = z;
        if (z > s2c_pkg::HALF_PI_Q28) begin
            f.z    = z - s2c_pkg::PI_Q28;
            f.flip = 1'b1;
        end
        else if (z < -s2c_pkg::HALF_PI_Q28) begin
            f.z    = z + s2c_pkg::PI_Q28;
            f.flip = 1'b1;
        end
        return f;
    endfunction

    // round q2.30 product to nearest, halves up, then clamp to 16 bits
    function automatic logic signed [15:0] rnd_sat(input logic signed [47:0] v);
        logic signed [47:0] s;
        logic signed [47:0] r;
        logic signed [15:0] o;
        s = v + 48'sd536870912;
        r = s >>> 30;
        if (r > 48'sd32767) begin
            o = 16'sh7fff;
        end
        else if (r < -48'sd32768) begin
            o = 16'sh8000;
        end
        else begin
            o = r[15:0];
        end
        return o;
    endfunction

    // pipeline control: every stage moves together when the output slot is free or its result is being taken
    logic             adv;
    logic [DEPTH-1:0] vld_reg;

    assign adv         = !vld_reg[DEPTH-1] || coord_ready;
    assign point_ready = adv;
    assign coord_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], point_valid};
        end
    end

    // cordic datapath, index 0 is the fold stage, index k the output of iteration k-1
    logic signed [31:0] az_x_reg [0:NSTG];
    logic signed [31:0] az_y_reg [0:NSTG];
    logic signed [31:0] az_z_reg [0:NSTG];
    logic signed [31:0] pl_x_reg [0:NSTG];
    logic signed [31:0] pl_y_reg [0:NSTG];
    logic signed [31:0] pl_z_reg [0:NSTG];
    logic               az_flip_reg [0:NSTG];
    logic               pl_flip_reg [0:NSTG];
    logic signed [15:0] rad_reg [0:NSTG];

    fold_t az_fold;
    fold_t pl_fold;

    always_comb
    begin
        az_fold = fold_angle(point.azimuth_angle);
        pl_fold = fold_angle(point.polar_angle);
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            az_x_reg[0]    <= s2c_pkg::CORDIC_GAIN_Q30;
            az_y_reg[0]    <= '0;
            az_z_reg[0]    <= az_fold.z;
            az_flip_reg[0] <= az_fold.flip;
            pl_x_reg[0]    <= s2c_pkg::CORDIC_GAIN_Q30;
            pl_y_reg[0]    <= '0;
            pl_z_reg[0]    <= pl_fold.z;
            pl_flip_reg[0] <= pl_fold.flip;
            rad_reg[0]     <= point.radius;
        end
    end

    // one rotation per stage, shift amount and arctangent fixed per stage
    for (genvar k = 0; k < NSTG; k++) begin : g_cordic
        localparam logic signed [31:0] ATAN = s2c_pkg::atan_q28(k);

        always_ff @(posedge clk) begin
            if (adv) begin
                if (!az_z_reg[k][31]) begin
                    az_x_reg[k+1] <= az_x_reg[k] - (az_y_reg[k] >>> k);
                    az_y_reg[k+1] <= az_y_reg[k] + (az_x_reg[k] >>> k);
                    az_z_reg[k+1] <= az_z_reg[k] - ATAN;
                end
                else begin
                    az_x_reg[k+1] <= az_x_reg[k] + (az_y_reg[k] >>> k);
                    az_y_reg[k+1] <= az_y_reg[k] - (az_x_reg[k] >>> k);
                    az_z_reg[k+1] <= az_z_reg[k] + ATAN;
                end
                if (!pl_z_reg[k][31]) begin
                    pl_x_reg[k+1] <= pl_x_reg[k] - (pl_y_reg[k] >>> k);
                    pl_y_reg[k+1] <= pl_y_reg[k] + (pl_x_reg[k] >>> k);
                    pl_z_reg[k+1] <= pl_z_reg[k] - ATAN;
                end
                else begin
                    pl_x_reg[k+1] <= pl_x_reg[k] + (pl_y_reg[k] >>> k);
                    pl_y_reg[k+1] <= pl_y_reg[k] - (pl_x_reg[k] >>> k);
                    pl_z_reg[k+1] <= pl_z_reg[k] + ATAN;
                end
                az_flip_reg[k+1] <= az_flip_reg[k];
                pl_flip_reg[k+1] <= pl_flip_reg[k];
                rad_reg[k+1]     <= rad_reg[k];
            end
        end
    end

    // first multiply: sin(polar) times cos and sin of azimuth
    // flips are carried as one sign for the products, cos(polar) is negated directly
    logic signed [63:0] pa_prod_reg;
    logic signed [63:0] pq_prod_reg;
    logic               prod_neg_reg;
    logic signed [31:0] cp1_reg;
    logic signed [15:0] rad1_reg;

    always_ff @(posedge clk) begin
        if (adv) begin
            pa_prod_reg  <= pl_y_reg[NSTG] * az_x_reg[NSTG];
            pq_prod_reg  <= pl_y_reg[NSTG] * az_y_reg[NSTG];
            prod_neg_reg <= az_flip_reg[NSTG] ^ pl_flip_reg[NSTG];
            cp1_reg      <= pl_flip_reg[NSTG] ? -pl_x_reg[NSTG] : pl_x_reg[NSTG];
            rad1_reg     <= rad_reg[NSTG];
        end
    end

    // round products back to q2.30; -v + h is folded into ~v + (h + 1)
    logic signed [63:0] pa_sum;
    logic signed [63:0] pq_sum;
    logic signed [63:0] pa_rnd;
    logic signed [63:0] pq_rnd;

    always_comb
    begin
        if (prod_neg_reg) begin
            pa_sum = ~pa_prod_reg + (s2c_pkg::HALF_Q30 + 64'sd1);
            pq_sum = ~pq_prod_reg + (s2c_pkg::HALF_Q30 + 64'sd1);
        end
        else begin
            pa_sum = pa_prod_reg + s2c_pkg::HALF_Q30;
            pq_sum = pq_prod_reg + s2c_pkg::HALF_Q30;
        end
        pa_rnd = pa_sum >>> 30;
        pq_rnd = pq_sum >>> 30;
    end

    logic signed [31:0] p_reg;
    logic signed [31:0] q_reg;
    logic signed [31:0] cp2_reg;
    logic signed [15:0] rad2_reg;

    always_ff @(posedge clk) begin
        if (adv) begin
            p_reg    <= pa_rnd[31:0];
            q_reg    <= pq_rnd[31:0];
            cp2_reg  <= cp1_reg;
            rad2_reg <= rad1_reg;
        end
    end

    // second multiply: scale by radius
    logic signed [47:0] x_prod_reg;
    logic signed [47:0] y_prod_reg;
    logic signed [47:0] z_prod_reg;

    always_ff @(posedge clk) begin
        if (adv) begin
            x_prod_reg <= rad2_reg * p_reg;
            y_prod_reg <= rad2_reg * q_reg;
            z_prod_reg <= rad2_reg * cp2_reg;
        end
    end

    // output register: round and saturate
    s2c_pkg::coord_t coord_reg;

    always_ff @(posedge clk) begin
        if (adv) begin
            coord_reg.x_coord <= rnd_sat(x_prod_reg);
            coord_reg.y_coord <= rnd_sat(y_prod_reg);
            coord_reg.z_coord <= rnd_sat(z_prod_reg);
        end
    end

    assign coord = coord_reg;

endmodule

/* hdl/s2c_chk.sv */
module s2c_chk #(
    parameter int MAX_INFLIGHT = s2c_pkg::CORDIC_STAGES_DEF + 5
) (
    input logic            clk,
    input logic            rst_n,
    input logic            point_valid,
    input logic            point_ready,
    input logic            coord_valid,
    input logic            coord_ready,
    input s2c_pkg::coord_t coord
);

    // points taken but not yet delivered
    logic [7:0] cnt_reg;
    logic [7:0] cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (point_valid && point_ready) begin
            cnt_next = cnt_next + 8'd1;
        end
        if (coord_valid && coord_ready) begin
            cnt_next = cnt_next - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end
        else begin
            cnt_reg <= cnt_next;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        coord_valid && !coord_ready |=> coord_valid && $stable(coord))
        else $error("result changed while stalled");

    // no result without a point behind it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        coord_valid |-> cnt_reg != 8'd0)
        else $error("result with no point in flight");

    // pipeline never holds more points than it has stages
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 8'(MAX_INFLIGHT))
        else $error("more points in flight than stages");

    // a free or draining output slot lets a new point in
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!coord_valid || coord_ready) |-> point_ready)
        else $error("input blocked while output slot free");

endmodule

bind spherical_to_cartesian s2c_chk #(.MAX_INFLIGHT(CORDIC_STAGES + 5)) u_s2c_chk (.*);

/* dv/coord_check_pkg.sv */
`timescale 1ns / 100ps

package coord_check_pkg;

    class coord_scoreboard;

        int              stages;
        longint          atan_step[24];
        s2c_pkg::coord_t expected_coords[$];
        int              points_in;
        int              coords_out;
        int              errors;

        function new(int n_stages);
            stages     = n_stages;
            points_in  = 0;
            coords_out = 0;
            errors     = 0;
            // atan(2^-i) in units of 2^-28 rad
            atan_step  = '{210828714, 124459457, 65760959, 33381290,
                           16755422, 8385879, 4193963, 2097109,
                           1048571, 524287, 262144, 131072,
                           65536, 32768, 16384, 8192,
                           4096, 2048, 1024, 512,
                           256, 128, 64, 32};
        endfunction

        function int pending();
            return expected_coords.size();
        endfunction

        function longint round_q30(longint v);
            return (v + longint'(s2c_pkg::HALF_Q30)) >>> 30;
        endfunction

        function logic signed [15:0] clamp16(longint v);
            if (v > 32767)
                return 16'sh7fff;
            if (v < -32768)
                return 16'sh8000;
            return 16'(v);
        endfunction

        // rotation mode cordic, angles folded into [-pi/2, pi/2] first
        function void sin_cos(input logic signed [15:0] ang,
                              output longint s, output longint c);
            longint zz;
            longint xx;
            longint yy;
            longint dx;
            longint dy;
            bit     flip;
            zz   = longint'(ang) * 32768;
            xx   = longint'(s2c_pkg::CORDIC_GAIN_Q30);
            yy   = 0;
            flip = 1'b0;
            if (zz > longint'(s2c_pkg::HALF_PI_Q28))
            begin
                zz   = zz - longint'(s2c_pkg::PI_Q28);
                flip = 1'b1;
            end
            else if (zz < -longint'(s2c_pkg::HALF_PI_Q28))
            begin
                zz   = zz + longint'(s2c_pkg::PI_Q28);
                flip = 1'b1;
            end
            for (int i = 0; i < stages && i < 24; i++)
            begin
                dx = yy >>> i;
                dy = xx >>> i;
                if (zz >= 0)
                begin
                    xx = xx - dx;
                    yy = yy + dy;
                    zz = zz - atan_step[i];
                end
                else
                begin
                    xx = xx + dx;
                    yy = yy - dy;
                    zz = zz + atan_step[i];
                end
            end
            if (flip)
            begin
                xx = -xx;
                yy = -yy;
            end
            s = yy;
            c = xx;
        endfunction

        function s2c_pkg::coord_t predict_coord(s2c_pkg::point_t p);
            longint          sa;
            longint          ca;
            longint          sp;
            longint          cp;
            longint          px;
            longint          py;
            longint          rr;
            s2c_pkg::coord_t c;
            sin_cos(p.azimuth_angle, sa, ca);
            sin_cos(p.polar_angle, sp, cp);
            px = round_q30(sp * ca);
            py = round_q30(sp * sa);
            rr = longint'(p.radius);
            c.x_coord = clamp16(round_q30(rr * px));
            c.y_coord = clamp16(round_q30(rr * py));
            c.z_coord = clamp16(round_q30(rr * cp));
            return c;
        endfunction

        function void note_point(s2c_pkg::point_t p);
            expected_coords.push_back(predict_coord(p));
            points_in++;
        endfunction

        function void check_coord(s2c_pkg::coord_t got);
            s2c_pkg::coord_t want;
            coords_out++;
            if (expected_coords.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected coord x=%0d y=%0d z=%0d, no point pending",
                             got.x_coord, got.y_coord, got.z_coord);
                return;
            end
            want = expected_coords.pop_front();
            if (got.x_coord !== want.x_coord || got.y_coord !== want.y_coord ||
                got.z_coord !== want.z_coord)
            begin
                errors++;
                if (errors <= 10)
                    $display("coord %0d mismatch: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                             coords_out, want.x_coord, want.y_coord, want.z_coord,
                             got.x_coord, got.y_coord, got.z_coord);
            end
        endfunction

    endclass

endpackage

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int STAGES  = s2c_pkg::CORDIC_STAGES_DEF;
    // input transfer to output valid, as deep as the block's pipeline
    localparam int LATENCY = STAGES + 5;
    // cycles in a row with no transfer on either side before giving up
    localparam int QUIET_LIMIT = 1000;
    localparam int CHUNKS      = 8;
    localparam int CHUNK_SIZE  = 200;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            point_valid;
    logic            point_ready;
    s2c_pkg::point_t point;
    logic            coord_valid;
    logic            coord_ready;
    s2c_pkg::coord_t coord;

    // bit 0: sender inserts gaps, bit 1: receiver stalls
    logic [1:0] idle_mode;
    int         quiet_cycles;

    coord_check_pkg::coord_scoreboard board;

    spherical_to_cartesian #(
        .CORDIC_STAGES (STAGES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .coord_valid (coord_valid),
        .coord_ready (coord_ready),
        .coord       (coord)
    );

    always #2 clk = ~clk;

    // gap draw for one transfer, zero when that side is not idling
    function automatic int draw_gap(logic enable);
        return enable ? int'($urandom_range(0, 5)) : 0;
    endfunction

    // angle mostly in [-pi, pi], sometimes any 16-bit code or a fold boundary
    function automatic logic signed [15:0] random_angle();
        int          k;
        int          a;
        logic [31:0] w;
        k = $urandom_range(0, 9);
        w = $urandom();
        if (k < 7)
            a = int'($urandom_range(0, 51472)) - 25736;
        else if (k < 9)
            a = int'($signed(w[15:0]));
        else
        begin
            case (w[2:0])
                3'd0:    a = 12868;
                3'd1:    a = 12867;
                3'd2:    a = -12868;
                3'd3:    a = -12867;
                3'd4:    a = 25736;
                3'd5:    a = -25736;
                default: a = 0;
            endcase
        end
        return 16'(a);
    endfunction

    function automatic logic signed [15:0] random_radius();
        logic [31:0] w;
        w = $urandom();
        if (w[31:29] != 3'd0)
            return w[15:0];
        // full-scale, zero or minus-one radius now and then; full scale is where saturation shows up
        case (w[17:16])
            2'd0:    return 16'sh8000;
            2'd1:    return 16'sh7fff;
            2'd2:    return 16'sh0000;
            default: return 16'shffff;
        endcase
    endfunction

    // one input transfer: optional gap, then hold valid until accepted
    task automatic send_point(input s2c_pkg::point_t p);
        int gap;
        gap = draw_gap(idle_mode[0]);
        if (gap > 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_valid <= 1'b1;
        point       <= p;
        do @(posedge clk); while (!point_ready);
        board.note_point(p);
    endtask

    task automatic send_fields(input int az, input int pol, input int r);
        s2c_pkg::point_t p;
        p.azimuth_angle = 16'(az);
        p.polar_angle   = 16'(pol);
        p.radius        = 16'(r);
        send_point(p);
    endtask

    // stop sending and let every pending coord come out
    task automatic drain();
        point_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // result side: random stalls, each output transfer goes to the scoreboard
    initial
    begin
        int gap;
        coord_ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(idle_mode[1]);
            if (gap > 0)
            begin
                coord_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            coord_ready <= 1'b1;
            do @(posedge clk); while (!coord_valid);
            board.check_coord(coord);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((point_valid && point_ready) || (coord_valid && coord_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("no transfer for %0d cycles, %0d coords pending",
                     quiet_cycles, board.pending());
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        s2c_pkg::point_t p;
        board = new(STAGES);
        idle_mode    = 2'b11;
        rst_n       <= 1'b0;
        point_valid <= 1'b0;
        point       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, full-scale radius, angles at +-pi and at the half-pi fold
        send_fields(0, 0, 0);
        send_fields(0, 0, 32767);
        send_fields(0, 0, -32768);
        send_fields(0, 25736, -32768);     // cos(pi) times most negative radius saturates
        send_fields(0, 25736, 32767);
        send_fields(0, 12868, 32767);      // just past half pi, folded
        send_fields(0, 12867, 32767);      // just below half pi, not folded
        send_fields(12868, 12868, -32768);
        send_fields(-12868, -12868, 32767);
        send_fields(-12867, 12867, 1000);
        send_fields(25736, -25736, -1);
        send_fields(-25736, 20000, 1);
        send_fields(32767, -32768, 32767); // codes outside [-pi, pi]
        send_fields(-32768, 32767, -32768);
        send_fields(20000, -20000, 12345);
        send_fields(-20000, 6434, -12345);
        send_fields(6434, 6434, 16384);
        send_fields(8192, -8192, -16384);
        send_fields(-1, 1, 32767);
        send_fields(1, -1, -32768);

        // sender holds off until the pipeline is empty
        drain();

        // random: chunks cycle through all four idle combinations
        for (int c = 0; c < CHUNKS; c++)
        begin
            idle_mode = 2'((c + 3) % 4);
            if (c == CHUNKS / 2)
                drain();
            for (int n = 0; n < CHUNK_SIZE; n++)
            begin
                p.azimuth_angle = random_angle();
                p.polar_angle   = random_angle();
                p.radius        = random_radius();
                send_point(p);
            end
        end

        drain();
        repeat (LATENCY + 4) @(posedge clk);

        $display("converted %0d points into %0d coord transfers, %0d mismatches",
                 board.points_in, board.coords_out, board.errors);
        $display("angles over the whole 16-bit code range, stalls on either side and none");
        if (board.errors == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
